// ===== rtl/core/sbc_pkg.sv =====
`timescale 1ns / 1ps

package sbc_pkg;

    // Fraction bits of the Q formats for position, velocity and radius.
    localparam int FB = 16;
    // Fraction bits of the restitution.
    localparam int EB = 16;
    // Radius width, and the widths that follow from it.
    localparam int RW = 24;
    localparam int DW = RW + 1;          // offset on overlap, signed
    localparam int SW = 2 * RW;          // squared radius
    localparam int NW = FB + 2;          // unit normal component, signed
    localparam int QW = FB + 1;          // normal magnitude from the divider
    localparam int UW = RW + FB;         // divider numerator

    // Squared-length threshold, 1e-8 in Q(2*FB).
    localparam logic [SW+1:0] EPS_SQ = (SW+2)'((64'd1 << (2 * FB)) / 64'd100000000);

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COLLIDE = 1'b1;

    typedef struct packed {
        logic               action;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic [23:0]        sphere_radius;
        logic [16:0]        bounce_factor;
    } t_sbc_in;

    typedef struct packed {
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic signed [31:0] out_vel_z;
        logic               hit;
    } t_sbc_out;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        logic signed [31:0] y;
        if (x > 40'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -40'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

// ===== rtl/core/sbc_isqrt.sv =====
`timescale 1ns / 1ps

module sbc_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [sbc_pkg::SW-1:0]   i_val,
    output logic                     o_done,
    output logic [sbc_pkg::RW-1:0]   o_root
);
    import sbc_pkg::*;

    logic [SW-1:0] r_rem, r_res, r_bit;
    logic          r_busy, r_done;
    logic [SW-1:0] w_try;

    // One result bit per cycle, two bits of the operand consumed each step.
    assign w_try = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_val;
                r_res  <= '0;
                r_bit  <= SW'(1) << (SW - 2);
            end else if (r_busy) begin
                if (r_rem >= w_try) begin
                    r_rem <= r_rem - w_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0] || r_bit[1]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[RW-1:0];

endmodule

// ===== rtl/core/sbc_div.sv =====
`timescale 1ns / 1ps

module sbc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [sbc_pkg::UW-1:0]   i_num,
    input  logic [sbc_pkg::RW-1:0]   i_den,
    output logic                     o_done,
    output logic [sbc_pkg::QW-1:0]   o_quo
);
    import sbc_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [UW-1:0] r_rem, r_den;
    logic [QW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    // Restoring division, one quotient bit per cycle; the quotient is known
    // to stay below 2^QW, so only QW steps are needed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_num;
                r_den  <= UW'(i_den) << FB;
                r_quo  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_rem >= r_den) begin
                    r_rem <= r_rem - r_den;
                    r_quo <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[QW-2:0], 1'b0};
                end
                r_den <= r_den >> 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/core/sphere_box_collision_response_unit.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Payload
// request   | in        | i_valid / o_ready  | i_req (sbc_pkg::t_sbc_in)
// result    | out       | o_valid / i_ready  | o_rsp (sbc_pkg::t_sbc_out)
//
// A load request is taken while the block is idle and produces no result.
// After a collide request is taken, o_ready stays low until its result enters the output
// register. When one axis alone rules out contact or the squared-length test misses, the
// request ends early; a hit runs the 24-step square root and the three 17-step divisions
// for the normal, then reflects an approaching velocity, all around one shared multiplier.
// Reset is synchronous and active low; it clears the stored box to zero.
// A finished collide waits in its last state while the output register still holds
// an unaccepted result, so a stalled result holds back only the request after it.

module sphere_box_collision_response_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  sbc_pkg::t_sbc_in   i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output sbc_pkg::t_sbc_out  o_rsp
);
    import sbc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RR_M  = 4'd1;
    localparam logic [3:0] S_RR_A  = 4'd2;
    localparam logic [3:0] S_SQ_M  = 4'd3;
    localparam logic [3:0] S_SQ_A  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIV_S = 4'd7;
    localparam logic [3:0] S_DIV_W = 4'd8;
    localparam logic [3:0] S_NP_M  = 4'd9;
    localparam logic [3:0] S_NP_A  = 4'd10;
    localparam logic [3:0] S_VN_M  = 4'd11;
    localparam logic [3:0] S_VN_A  = 4'd12;
    localparam logic [3:0] S_K_M   = 4'd13;
    localparam logic [3:0] S_KN    = 4'd14;
    localparam logic [3:0] S_FIN   = 4'd15;

    // Box corners, live across requests.
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];

    // Working set of the collide request in flight.
    logic [3:0]             r_state;
    logic [1:0]             r_idx;
    logic                   r_kphase;
    logic signed [31:0]     r_p [3];
    logic signed [31:0]     r_v [3];
    logic signed [DW-1:0]   r_d [3];
    logic signed [NW-1:0]   r_n [3];
    logic [RW-1:0]          r_r;
    logic [16:0]            r_e;
    logic [SW-1:0]          r_rr;
    logic [SW+1:0]          r_s;
    logic [DW-1:0]          r_pen;
    logic signed [51:0]     r_vn_acc;
    logic signed [39:0]     r_k;
    logic signed [65:0]     r_prod;
    logic                   r_hit;
    logic                   r_out_valid;
    t_sbc_out               r_out;

    logic                   w_acc;
    logic signed [32:0]     w_d33 [3];
    logic                   w_far;
    logic signed [39:0]     w_ma;
    logic signed [25:0]     w_mb;
    logic signed [65:0]     w_sh;
    logic signed [DW-1:0]   w_dc;
    logic signed [NW-1:0]   w_nc;
    logic [RW-1:0]          w_dmag;
    logic                   w_sq_start, w_sq_done, w_dv_start, w_dv_done;
    logic [RW-1:0]          w_root;
    logic [QW-1:0]          w_quo;
    logic signed [35:0]     w_vn;

    // The divisor is the distance, held once the root is known.
    logic [RW-1:0] w_root_q;
    logic [RW-1:0] r_dist;

    // Marks that the product waiting in S_KN is (1+e)*vn rather than k*n.
    logic r_k_pending;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;

    // Clamp to the box (minimum first, then maximum) and the offset per axis;
    // any axis at or beyond the radius rules out an overlap straight away.
    always_comb begin
        logic signed [31:0] p, c;
        logic signed [33:0] d34, r34;
        w_far = 1'b0;
        r34   = $signed({10'b0, i_req.sphere_radius});
        for (int i = 0; i < 3; i++) begin
            p = (i == 0) ? i_req.a_x : ((i == 1) ? i_req.a_y : i_req.a_z);
            c = (p < r_lo[i]) ? r_lo[i] : ((p > r_hi[i]) ? r_hi[i] : p);
            w_d33[i] = {p[31], p} - {c[31], c};
            d34 = {w_d33[i][32], w_d33[i]};
            if (d34 >= r34 || -d34 >= r34) begin
                w_far = 1'b1;
            end
        end
    end

    assign w_dc   = r_d[r_idx];
    assign w_nc   = r_n[r_idx];
    assign w_dmag = w_dc[DW-1] ? RW'(-w_dc) : RW'(w_dc);
    assign w_sh   = r_prod >>> FB;
    assign w_vn   = r_vn_acc[51:FB];

    // Operand selection for the one shared multiplier.
    always_comb begin
        case (r_state)
            S_RR_M: begin
                w_ma = $signed({16'b0, r_r});
                w_mb = $signed({2'b0, r_r});
            end
            S_SQ_M: begin
                w_ma = 40'(w_dc);
                w_mb = 26'(w_dc);
            end
            S_NP_M: begin
                w_ma = 40'(w_nc);
                w_mb = $signed({1'b0, r_pen});
            end
            S_VN_M: begin
                w_ma = 40'(r_v[r_idx]);
                w_mb = 26'(w_nc);
            end
            S_K_M: begin
                w_ma = 40'(w_vn);
                w_mb = $signed({8'b0, 18'd65536 + {1'b0, r_e}});
            end
            S_KN: begin
                w_ma = r_k;
                w_mb = 26'(w_nc);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_sq_start = (r_state == S_CHK) && (r_s < {2'b0, r_rr}) && (r_s > EPS_SQ);
    assign w_dv_start = (r_state == S_DIV_S);
    assign w_root_q   = r_dist;

    sbc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_s[SW-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    sbc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_num   (UW'(w_dmag) << FB),
        .i_den   (w_root_q),
        .o_done  (w_dv_done),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_kphase    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
            end
        end else begin
            // In S_FIN the output register is refilled below instead.
            if (r_out_valid && i_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (i_req.action == ACT_LOAD) begin
                            r_lo[0] <= i_req.a_x;
                            r_lo[1] <= i_req.a_y;
                            r_lo[2] <= i_req.a_z;
                            r_hi[0] <= i_req.b_x;
                            r_hi[1] <= i_req.b_y;
                            r_hi[2] <= i_req.b_z;
                        end else begin
                            r_p[0] <= i_req.a_x;
                            r_p[1] <= i_req.a_y;
                            r_p[2] <= i_req.a_z;
                            r_v[0] <= i_req.b_x;
                            r_v[1] <= i_req.b_y;
                            r_v[2] <= i_req.b_z;
                            for (int i = 0; i < 3; i++) begin
                                r_d[i] <= w_d33[i][DW-1:0];
                            end
                            r_r      <= i_req.sphere_radius;
                            r_e      <= i_req.bounce_factor;
                            r_hit    <= 1'b0;
                            r_s      <= '0;
                            r_vn_acc <= '0;
                            r_idx    <= '0;
                            r_state  <= w_far ? S_FIN : S_RR_M;
                        end
                    end
                end
                S_RR_M: r_state <= S_RR_A;
                S_RR_A: begin
                    r_rr    <= r_prod[SW-1:0];
                    r_state <= S_SQ_M;
                end
                S_SQ_M: r_state <= S_SQ_A;
                S_SQ_A: begin
                    r_s <= r_s + {2'b0, r_prod[SW-1:0]};
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_CHK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SQ_M;
                    end
                end
                S_CHK: begin
                    r_state <= w_sq_start ? S_SQRT : S_FIN;
                    r_hit   <= w_sq_start;
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_dist  <= w_root;
                        r_pen   <= {1'b0, r_r} - {1'b0, w_root};
                        r_state <= S_DIV_S;
                    end
                end
                S_DIV_S: r_state <= S_DIV_W;
                S_DIV_W: begin
                    if (w_dv_done) begin
                        r_n[r_idx] <= w_dc[DW-1] ? -$signed({1'b0, w_quo})
                                                 : $signed({1'b0, w_quo});
                        r_state    <= S_NP_M;
                    end
                end
                S_NP_M: r_state <= S_NP_A;
                S_NP_A: begin
                    r_p[r_idx] <= sat32(40'(r_p[r_idx]) + w_sh[39:0]);
                    r_state    <= S_VN_M;
                end
                S_VN_M: r_state <= S_VN_A;
                S_VN_A: begin
                    r_vn_acc <= r_vn_acc + r_prod[51:0];
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_K_M;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_DIV_S;
                    end
                end
                S_K_M: begin
                    // Only an approaching sphere has its velocity reflected.
                    if (!w_vn[35]) begin
                        r_state <= S_FIN;
                    end else begin
                        r_kphase <= 1'b1;
                        r_state  <= S_KN;
                    end
                end
                S_KN: begin
                    // Alternates between issuing a product and using it; the
                    // first use takes k itself, later ones update a velocity.
                    r_kphase <= ~r_kphase;
                    if (r_kphase) begin
                        if (r_k_pending) begin
                            r_k <= 40'(r_prod >>> EB);
                        end else begin
                            r_v[r_idx] <= sat32(40'(r_v[r_idx]) - w_sh[39:0]);
                            if (r_idx == 2'd2) begin
                                r_state <= S_FIN;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.out_pos_x <= r_p[0];
                        r_out.out_pos_y <= r_p[1];
                        r_out.out_pos_z <= r_p[2];
                        r_out.out_vel_x <= r_v[0];
                        r_out.out_vel_y <= r_v[1];
                        r_out.out_vel_z <= r_v[2];
                        r_out.hit       <= r_hit;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_pending <= 1'b0;
        end else if (r_state == S_K_M) begin
            r_k_pending <= 1'b1;
        end else if (r_state == S_KN && r_kphase) begin
            r_k_pending <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

endmodule

// ===== dv/tb_sphere_box_collision_response_unit.sv =====
`timescale 1ns / 1ps

// Scoreboard: keeps its own copy of the stored box, works out the response
// to every accepted collide request and compares it with what comes out.
class sbc_response_board;
    logic signed [63:0] box_lo[3];
    logic signed [63:0] box_hi[3];
    sbc_pkg::t_sbc_out  pending[$];
    int                 n_err;
    int                 n_hits;
    int                 n_checked;

    function new();
        for (int i = 0; i < 3; i++) begin
            box_lo[i] = 0;
            box_hi[i] = 0;
        end
        n_err = 0;
        n_hits = 0;
        n_checked = 0;
    endfunction

    static function logic signed [63:0] floor_shift(logic signed [63:0] x, int sh);
        return x >>> sh;
    endfunction

    static function logic signed [31:0] clip32(logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    static function logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Notes an accepted request: a load updates the box, a collide queues
    // the expected response.
    function void note_request(sbc_pkg::t_sbc_in rq);
        logic signed [63:0] p[3], v[3], d[3], nrm[3], c;
        logic signed [63:0] rad, dlen, pen, vn, k, e;
        logic [63:0]        sq, eps;
        logic               hit;
        sbc_pkg::t_sbc_out  rs;
        if (rq.action == sbc_pkg::ACT_LOAD) begin
            box_lo[0] = rq.a_x; box_lo[1] = rq.a_y; box_lo[2] = rq.a_z;
            box_hi[0] = rq.b_x; box_hi[1] = rq.b_y; box_hi[2] = rq.b_z;
            return;
        end
        p[0] = rq.a_x; p[1] = rq.a_y; p[2] = rq.a_z;
        v[0] = rq.b_x; v[1] = rq.b_y; v[2] = rq.b_z;
        rad = {40'd0, rq.sphere_radius};
        hit = 1'b1;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            c = (p[i] < box_lo[i]) ? box_lo[i] : ((p[i] > box_hi[i]) ? box_hi[i] : p[i]);
            d[i] = p[i] - c;
            if (d[i] >= rad || -d[i] >= rad) hit = 1'b0;
        end
        eps = (64'd1 << (2 * sbc_pkg::FB)) / 64'd100000000;
        if (hit) begin
            for (int i = 0; i < 3; i++) sq = sq + d[i] * d[i];
            if (!(sq < rad * rad && sq > eps)) hit = 1'b0;
        end
        if (hit) begin
            e = {47'd0, rq.bounce_factor};
            dlen = floor_sqrt(sq);
            pen = rad - dlen;
            vn = 0;
            for (int i = 0; i < 3; i++) begin
                nrm[i] = (d[i] * (64'sd1 <<< sbc_pkg::FB)) / dlen;
                p[i] = clip32(p[i] + floor_shift(nrm[i] * pen, sbc_pkg::FB));
                vn = vn + v[i] * nrm[i];
            end
            vn = floor_shift(vn, sbc_pkg::FB);
            if (vn < 0) begin
                k = floor_shift(vn * (64'sd65536 + e), sbc_pkg::EB);
                for (int i = 0; i < 3; i++)
                    v[i] = clip32(v[i] - floor_shift(k * nrm[i], sbc_pkg::FB));
            end
            n_hits++;
        end
        rs.out_pos_x = p[0][31:0]; rs.out_pos_y = p[1][31:0]; rs.out_pos_z = p[2][31:0];
        rs.out_vel_x = v[0][31:0]; rs.out_vel_y = v[1][31:0]; rs.out_vel_z = v[2][31:0];
        rs.hit = hit;
        pending.push_back(rs);
    endfunction

    // Compares one accepted response with the oldest expectation.
    function void check_response(sbc_pkg::t_sbc_out got);
        sbc_pkg::t_sbc_out exp_r;
        if (pending.size() == 0) begin
            $error("response with nothing expected: %h", got);
            n_err++;
            return;
        end
        exp_r = pending.pop_front();
        n_checked++;
        if (got.out_pos_x !== exp_r.out_pos_x) begin
            $error("out_pos_x expected %0d got %0d", exp_r.out_pos_x, got.out_pos_x); n_err++;
        end
        if (got.out_pos_y !== exp_r.out_pos_y) begin
            $error("out_pos_y expected %0d got %0d", exp_r.out_pos_y, got.out_pos_y); n_err++;
        end
        if (got.out_pos_z !== exp_r.out_pos_z) begin
            $error("out_pos_z expected %0d got %0d", exp_r.out_pos_z, got.out_pos_z); n_err++;
        end
        if (got.out_vel_x !== exp_r.out_vel_x) begin
            $error("out_vel_x expected %0d got %0d", exp_r.out_vel_x, got.out_vel_x); n_err++;
        end
        if (got.out_vel_y !== exp_r.out_vel_y) begin
            $error("out_vel_y expected %0d got %0d", exp_r.out_vel_y, got.out_vel_y); n_err++;
        end
        if (got.out_vel_z !== exp_r.out_vel_z) begin
            $error("out_vel_z expected %0d got %0d", exp_r.out_vel_z, got.out_vel_z); n_err++;
        end
        if (got.hit !== exp_r.hit) begin
            $error("hit expected %0b got %0b", exp_r.hit, got.hit); n_err++;
        end
    endfunction
endclass

module tb_sphere_box_collision_response_unit;
    import sbc_pkg::*;

    // Watchdog limit in cycles without any handshake. The busy spell of a hit
    // and the longest sender or receiver gap are both far shorter, so this
    // is ample.
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1100;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_ready = 1'b0;
    t_sbc_in  i_req = '0;
    logic     o_ready;
    logic     o_valid;
    t_sbc_out o_rsp;

    sbc_response_board board = new();
    int  quiet_cycles = 0;
    bit  calm_phase = 1'b0;   // no idling in the closing part of the run
    int  n_requests = 0;

    always #5 i_clk = ~i_clk;

    sphere_box_collision_response_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // Responses are checked at the edge where they are accepted; the
    // monitor and the receiver's ready both run off the same edge, reading
    // values that settled in the previous step.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_response(o_rsp);
        end
    end

    // The receiver stalls in random bursts and runs freely for random stretches in between.
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            if (!calm_phase && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 19);
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // The watchdog counts cycles in which neither channel moves a request
    // or a response.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired with %0d responses outstanding", board.pending.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Presents one request and holds it until it is taken. The expectation
    // is noted at the accepting edge, before the response can appear.
    task automatic send_request(input t_sbc_in rq);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= rq;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_request(rq);
        n_requests++;
    endtask

    task automatic load_box(input logic signed [31:0] lx, ly, lz, hx, hy, hz);
        t_sbc_in rq;
        rq = '0;
        rq.action = ACT_LOAD;
        rq.a_x = lx; rq.a_y = ly; rq.a_z = lz;
        rq.b_x = hx; rq.b_y = hy; rq.b_z = hz;
        rq.sphere_radius = $urandom;
        rq.bounce_factor = $urandom;
        send_request(rq);
    endtask

    task automatic collide(input logic signed [31:0] px, py, pz, vx, vy, vz,
                           input logic [23:0] rad, input logic [16:0] bounce);
        t_sbc_in rq;
        rq.action = ACT_COLLIDE;
        rq.a_x = px; rq.a_y = py; rq.a_z = pz;
        rq.b_x = vx; rq.b_y = vy; rq.b_z = vz;
        rq.sphere_radius = rad;
        rq.bounce_factor = bounce;
        send_request(rq);
    endtask

    // Holds the sender back until every expected response has arrived.
    task automatic drain_responses();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // A random coordinate: mostly near the box so that hits are common,
    // sometimes anywhere in the full range.
    function automatic logic signed [31:0] near_coord(input logic signed [31:0] centre);
        logic signed [31:0] r;
        case ($urandom_range(0, 9))
            0: r = $urandom;
            1: r = centre + $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: r = centre + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
        return r;
    endfunction

    function automatic logic [23:0] pick_radius();
        logic [23:0] r;
        case ($urandom_range(0, 7))
            0: r = $urandom;
            1: r = 24'hFFFFFF;
            2: r = $urandom_range(0, 3);
            default: r = $urandom_range(24'h1_0000, 24'h8_0000);
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_velocity();
        logic [31:0] r;
        case ($urandom_range(0, 5))
            0: r = $urandom;
            1: r = ($urandom_range(0, 1)) ? 32'h7FFFFFFF : 32'h80000000;
            default: r = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        endcase
        return r;
    endfunction

    initial begin
        logic signed [31:0] cx, cy, cz, hw;
        cx = 0;
        cy = 0;
        cz = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reset box is the origin point.
        collide(32'sh0000_8000, 0, 0, -32'sh0001_0000, 0, 0, 24'h01_0000, 17'd0);
        // Zero radius never hits.
        collide(0, 0, 0, 0, 0, 0, 24'd0, 17'h10000);
        // Tiny offset at or below the epsilon threshold.
        collide(1, 0, 0, -5, 0, 0, 24'h01_0000, 17'h10000);
        collide(2, 0, 0, -5, 0, 0, 24'h01_0000, 17'h10000);
        load_box(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
                 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
        // Moving towards the face, and moving away.
        collide(32'sh0001_8000, 0, 0, -32'sh0002_0000, 32'sh100, 0, 24'h01_0000, 17'h08000);
        collide(32'sh0001_8000, 0, 0, 32'sh0002_0000, 0, 0, 24'h01_0000, 17'h08000);
        // Far on one axis, corner hit, restitution above one.
        collide(32'sh0003_0000, 0, 0, -1, 0, 0, 24'h01_0000, 17'h10000);
        collide(32'sh0001_4000, 32'sh0001_4000, -32'sh0001_4000,
                -32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 24'h01_0000, 17'h1FFFF);
        // Velocity at the limits so the bounce saturates.
        collide(32'sh0001_8000, 0, 0, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                24'hFFFFFF, 17'h1FFFF);
        // Box at the extremes of the range, centre outside both ends.
        load_box(32'sh7FFF_0000, 32'sh80000000, 32'sh80000000,
                 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh8000_FFFF);
        collide(32'sh7FFFFFFF, 0, 32'sh8001_0000, 0, 0, -32'sh0001_0000, 24'hFFFFFF, 17'h10000);
        collide(32'sh7FFE_8000, 32'sh7FFFFFFF, 32'sh8000_FFFF, 32'sh0001_0000, 0, 0,
                24'hFFFFFF, 17'd0);
        // Inverted box: minimum above maximum.
        load_box(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 0, 0, 0);
        collide(32'sh0001_0000, 32'sh0001_8000, 32'sh0003_0000, 32'sh0001_0000, 0,
                -32'sh0001_0000, 24'h02_0000, 17'h04000);
        collide(32'sh0002_8000, 32'sh0002_0000, 32'sh0002_0000, -32'sh0001_0000, 0, 0,
                24'h01_0000, 17'h10000);
        drain_responses();

        // Random part: mostly a box then several spheres near it, with the
        // odd load of random corners thrown in.
        while (n_requests < RANDOM_ITEMS + 16) begin
            if (n_requests > RANDOM_ITEMS - 100) calm_phase = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                cx = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                cy = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                cz = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
                hw = $urandom_range(0, 32'h0004_0000);
                load_box(cx - hw, cy - hw, cz - hw, cx + hw, cy + hw, cz + hw);
            end
            repeat ($urandom_range(2, 12)) begin
                collide(near_coord(cx), near_coord(cy), near_coord(cz),
                        pick_velocity(), pick_velocity(), pick_velocity(),
                        pick_radius(), $urandom);
            end
            if (n_requests > 500 && n_requests < 520) drain_responses();
        end
        i_valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("%0d requests sent, %0d responses checked, %0d of them hits",
                 n_requests, board.n_checked, board.n_hits);
        if (board.n_err == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
